// ----- hdl/assert_macros.svh -----
// Concurrent assertion helpers, empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CAR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CAR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CAR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CAR_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ----- hdl/car_pkg.sv -----
package car_pkg;

  localparam int COORD_W    = 15;
  localparam int NUM_W      = 31;
  localparam int QUOT_W     = 15;
  localparam int DIVS_W     = 16;
  localparam int PIX_W      = 8;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd64;

  typedef struct packed {
    logic [COORD_W-1:0] bx;
    logic [COORD_W-1:0] by;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
  } piece_t;

  typedef struct packed {
    logic idle;
    logic clearing;
  } store_status_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic [POS_W-1:0] pixel_column;
    logic [POS_W-1:0] pixel_row;
    logic             last_pixel;
    logic             coverage_leftover;
  } result_t;

endpackage

// ----- hdl/car_ifs.sv -----
interface car_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [car_pkg::COORD_W-1:0]  x_begin;
  logic [car_pkg::COORD_W-1:0]  y_begin;
  logic [car_pkg::COORD_W-1:0]  x_end;
  logic [car_pkg::COORD_W-1:0]  y_end;
  modport source (output valid, kind, x_begin, y_begin, x_end, y_end, input ready);
  modport sink (input valid, kind, x_begin, y_begin, x_end, y_end, output ready);
endinterface

interface car_out_if;
  logic                        valid;
  logic                        ready;
  logic [car_pkg::PIX_W-1:0]   pixel_value;
  logic [car_pkg::POS_W-1:0]   pixel_column;
  logic [car_pkg::POS_W-1:0]   pixel_row;
  logic                        last_pixel;
  logic                        coverage_leftover;
  modport source (output valid, pixel_value, pixel_column, pixel_row, last_pixel,
                  coverage_leftover, input ready);
  modport sink (input valid, pixel_value, pixel_column, pixel_row, last_pixel,
                coverage_leftover, output ready);
endinterface

interface car_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [car_pkg::CFG_IDX_W-1:0]  index;
  logic [car_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/coverage_accumulation_rasterizer_unit.sv -----
// Signed-area coverage rasterizer. A draw beat (kind 0) walks its segment
// one pixel-edge crossing at a time; each crossing uses the 15-step
// crossing divider, and no further input beat is taken until the whole
// segment has been walked, with the cell read-modify-write of each piece
// overlapped with the next crossing. A readout beat (kind 1) goes through
// the cell memory read port and gives one result beat; it waits while the
// output register is still full. After reset all MAX_WIDTH*MAX_HEIGHT
// cells (4096 by default) of the cell memory are swept to zero, during
// which no input beat is taken; configuration writes always are.
`include "assert_macros.svh"

module coverage_accumulation_rasterizer_unit #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_HEIGHT    = 64,
  parameter int SUBPIXEL_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  car_in_if.sink    in_i,
  car_out_if.source out_o,
  car_cfg_if.sink   cfg_i
);

  localparam int UW = $clog2(MAX_WIDTH + 1);
  localparam int UH = $clog2(MAX_HEIGHT + 1);

  logic [car_pkg::CFG_DATA_W-1:0] width_q, height_q;
  logic [UW-1:0]                  used_w;
  logic [UH-1:0]                  used_h;

  logic                           walk_idle, piece_valid, piece_ready;
  car_pkg::piece_t                piece;
  logic                           div_start, div_done;
  logic [car_pkg::NUM_W-1:0]      div_num;
  logic [car_pkg::DIVS_W-1:0]     div_den;
  logic [car_pkg::QUOT_W-1:0]     div_quot;
  logic                           res_valid;
  car_pkg::result_t               res, out_q;
  car_pkg::store_status_t         st;
  logic                           out_valid_q, in_acc;

  always_comb begin
    if (width_q == '0) used_w = UW'(1);
    else if (int'(width_q) > MAX_WIDTH) used_w = UW'(MAX_WIDTH);
    else used_w = UW'(width_q);
    if (height_q == '0) used_h = UH'(1);
    else if (int'(height_q) > MAX_HEIGHT) used_h = UH'(MAX_HEIGHT);
    else used_h = UH'(height_q);
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= car_pkg::DIM_RESET;
      height_q <= car_pkg::DIM_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        car_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        car_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign in_i.ready = walk_idle && st.idle;
  assign in_acc     = in_i.valid && in_i.ready;

  car_walk #(.SUBPIXEL_BITS(SUBPIXEL_BITS)) u_walk (
    .clk_i, .rst_ni,
    .start_i        (in_acc && in_i.kind == car_pkg::KIND_DRAW),
    .x_begin_i      (in_i.x_begin),
    .y_begin_i      (in_i.y_begin),
    .x_end_i        (in_i.x_end),
    .y_end_i        (in_i.y_end),
    .idle_o         (walk_idle),
    .piece_valid_o  (piece_valid),
    .piece_ready_i  (piece_ready),
    .piece_o        (piece),
    .div_start_o    (div_start),
    .div_dividend_o (div_num),
    .div_divisor_o  (div_den),
    .div_done_i     (div_done),
    .div_quot_i     (div_quot)
  );

  car_div u_div (
    .clk_i, .rst_ni,
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  car_store #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .SUBPIXEL_BITS(SUBPIXEL_BITS)
  ) u_store (
    .clk_i, .rst_ni,
    .used_w_i      (used_w),
    .used_h_i      (used_h),
    .piece_valid_i (piece_valid),
    .piece_ready_o (piece_ready),
    .piece_i       (piece),
    .read_start_i  (in_acc && in_i.kind == car_pkg::KIND_READ),
    .out_free_i    (!out_valid_q),
    .res_valid_o   (res_valid),
    .res_o         (res),
    .status_o      (st)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) out_q <= res;
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.pixel_value       = out_q.pixel_value;
  assign out_o.pixel_column      = out_q.pixel_column;
  assign out_o.pixel_row         = out_q.pixel_row;
  assign out_o.last_pixel        = out_q.last_pixel;
  assign out_o.coverage_leftover = out_q.coverage_leftover;

  `CAR_ASSERT_NEVER(a_res_overwrite, clk_i, rst_ni, res_valid && out_valid_q, "result lost")
  `CAR_ASSERT_NEVER(a_take_in_clear, clk_i, rst_ni, st.clearing && in_i.ready, "beat in sweep")
  `CAR_ASSERT(a_piece_busy, clk_i, rst_ni, piece_valid && piece_ready |=> !st.idle, "piece dropped")
  `CAR_ASSERT(a_read_busy, clk_i, rst_ni, in_acc && in_i.kind |=> !st.idle, "readout dropped")

endmodule

// ----- hdl/car_div.sv -----
module car_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [car_pkg::NUM_W-1:0]    dividend_i,
  input  logic [car_pkg::DIVS_W-1:0]   divisor_i,
  output logic                         done_o,
  output logic [car_pkg::QUOT_W-1:0]   quot_o
);

  localparam int NW  = car_pkg::NUM_W;
  localparam int QW  = car_pkg::QUOT_W;
  localparam int CNW = $clog2(QW);

  logic           busy_q, done_q;
  logic [CNW-1:0] cnt_q;
  logic [NW-1:0]  rem_q, dsh_q;
  logic [QW-1:0]  quot_q;
  logic           fit;

  assign fit    = rem_q >= dsh_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNW'(QW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle, restoring
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= NW'(divisor_i) << (QW - 1);
      quot_q <= '0;
    end else if (busy_q) begin
      if (fit) begin
        rem_q <= rem_q - dsh_q;
      end
      quot_q <= {quot_q[QW-2:0], fit};
      dsh_q  <= dsh_q >> 1;
    end
  end

endmodule

// ----- hdl/car_walk.sv -----
module car_walk #(
  parameter int SUBPIXEL_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [car_pkg::COORD_W-1:0]  x_begin_i,
  input  logic [car_pkg::COORD_W-1:0]  y_begin_i,
  input  logic [car_pkg::COORD_W-1:0]  x_end_i,
  input  logic [car_pkg::COORD_W-1:0]  y_end_i,
  output logic                         idle_o,
  output logic                         piece_valid_o,
  input  logic                         piece_ready_i,
  output car_pkg::piece_t              piece_o,
  output logic                         div_start_o,
  output logic [car_pkg::NUM_W-1:0]    div_dividend_o,
  output logic [car_pkg::DIVS_W-1:0]   div_divisor_o,
  input  logic                         div_done_i,
  input  logic [car_pkg::QUOT_W-1:0]   div_quot_i
);

  localparam int Grain = 1 << SUBPIXEL_BITS;
  localparam int CW    = car_pkg::COORD_W;
  localparam int XW    = CW + 2;
  localparam int NW    = car_pkg::NUM_W;

  typedef enum logic [2:0] {
    W_IDLE, W_INIT, W_TEST, W_CMP, W_MUL, W_NUM, W_DIV, W_EMIT
  } state_e;

  state_e state_q;
  logic   div_start_q;

  logic [CW-1:0]          x0_q, y0_q, x1_q, y1_q, px_q, py_q;
  logic signed [CW:0]     dx_q, dy_q;
  logic [CW-1:0]          adx_q, ady_q;
  logic signed [XW-1:0]   xc_q, yc_q;
  logic                   xv_q, yv_q, selx_q, last_q;
  logic [CW:0]            ax_q, ay_q;
  logic [2*CW:0]          pa_q, pb_q;
  logic [CW-1:0]          b_q, den_q;
  logic [CW:0]            a_q;
  logic signed [CW:0]     d_q;
  logic [2*CW-1:0]        bd_q;
  logic signed [2*CW+2:0] ad_q;
  logic [NW-1:0]          num_q;
  car_pkg::piece_t        piece_q;

  logic signed [CW:0]     dx_w, dy_w;
  logic signed [XW-1:0]   x0f, y0f, xc_init, yc_init, x0e, y0e, x1e, y1e, difx, dify;
  logic [CW:0]            ax_w, ay_w;
  logic                   xv_w, yv_w, selx_w;
  logic signed [2*CW+2:0] a_s, d_s;
  logic signed [2*CW+4:0] sum_w, num_w;
  logic [CW-1:0]          qx_w, qy_w;

  always_comb begin
    dx_w = $signed({1'b0, x1_q}) - $signed({1'b0, x0_q});
    dy_w = $signed({1'b0, y1_q}) - $signed({1'b0, y0_q});
    x0f  = $signed({2'b00, x0_q[CW-1:SUBPIXEL_BITS], {SUBPIXEL_BITS{1'b0}}});
    y0f  = $signed({2'b00, y0_q[CW-1:SUBPIXEL_BITS], {SUBPIXEL_BITS{1'b0}}});
    xc_init = (dx_w > 0 && x0_q[SUBPIXEL_BITS-1:0] != '0) ? x0f + $signed(XW'(Grain)) : x0f;
    yc_init = (dy_w > 0 && y0_q[SUBPIXEL_BITS-1:0] != '0) ? y0f + $signed(XW'(Grain)) : y0f;
    x0e  = $signed({2'b00, x0_q});
    y0e  = $signed({2'b00, y0_q});
    x1e  = $signed({2'b00, x1_q});
    y1e  = $signed({2'b00, y1_q});
    difx = xc_q - x0e;
    dify = yc_q - y0e;
    ax_w = difx[XW-1] ? (CW+1)'(-difx) : (CW+1)'(difx);
    ay_w = dify[XW-1] ? (CW+1)'(-dify) : (CW+1)'(dify);
    xv_w = (dx_q > 0) ? (xc_q < x1e) : (xc_q > x1e);
    yv_w = (dy_q == 0) ? 1'b0 : ((dy_q > 0) ? (yc_q < y1e) : (yc_q > y1e));
    selx_w = xv_q && (!yv_q || pa_q < pb_q);
    a_s  = $signed({{(CW+2){1'b0}}, a_q});
    d_s  = $signed({{(CW+2){d_q[CW]}}, d_q});
    sum_w = $signed({5'b00000, bd_q}) + $signed({{2{ad_q[2*CW+2]}}, ad_q});
    num_w = (sum_w <<< 1) + $signed({{(CW+5){1'b0}}, den_q});
    qx_w = selx_q ? xc_q[CW-1:0] : div_quot_i;
    qy_w = selx_q ? div_quot_i : yc_q[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= W_IDLE;
      div_start_q <= 1'b0;
    end else begin
      div_start_q <= 1'b0;
      unique case (state_q)
        W_IDLE: if (start_i) state_q <= W_INIT;
        W_INIT: state_q <= (dx_w == 0) ? W_IDLE : W_TEST;
        W_TEST: state_q <= (!xv_w && !yv_w) ? W_EMIT : W_CMP;
        W_CMP:  state_q <= W_MUL;
        W_MUL:  state_q <= W_NUM;
        W_NUM: begin
          state_q     <= W_DIV;
          div_start_q <= 1'b1;
        end
        W_DIV:  if (div_done_i) state_q <= W_EMIT;
        W_EMIT: if (piece_ready_i) state_q <= last_q ? W_IDLE : W_TEST;
        default: state_q <= W_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      W_IDLE: begin
        x0_q <= x_begin_i;
        y0_q <= y_begin_i;
        x1_q <= x_end_i;
        y1_q <= y_end_i;
      end
      W_INIT: begin
        dx_q  <= dx_w;
        dy_q  <= dy_w;
        adx_q <= dx_w[CW] ? CW'(-dx_w) : CW'(dx_w);
        ady_q <= dy_w[CW] ? CW'(-dy_w) : CW'(dy_w);
        xc_q  <= xc_init;
        yc_q  <= yc_init;
        px_q  <= x0_q;
        py_q  <= y0_q;
      end
      W_TEST: begin
        xv_q <= xv_w;
        yv_q <= yv_w;
        ax_q <= ax_w;
        ay_q <= ay_w;
        pa_q <= (2*CW+1)'(ax_w) * (2*CW+1)'(ady_q);
        pb_q <= (2*CW+1)'(ay_w) * (2*CW+1)'(adx_q);
        last_q  <= 1'b1;
        piece_q <= '{bx: px_q, by: py_q, ex: x1_q, ey: y1_q};
      end
      W_CMP: begin
        selx_q <= selx_w;
        b_q    <= selx_w ? y0_q : x0_q;
        a_q    <= selx_w ? ax_q : ay_q;
        d_q    <= selx_w ? dy_q : dx_q;
        den_q  <= selx_w ? adx_q : ady_q;
      end
      W_MUL: begin
        bd_q <= (2*CW)'(b_q) * (2*CW)'(den_q);
        ad_q <= a_s * d_s;
      end
      W_NUM: begin
        num_q <= num_w[2*CW+4] ? '0 : num_w[NW-1:0];
      end
      W_DIV: begin
        if (div_done_i) begin
          last_q  <= 1'b0;
          piece_q <= '{bx: px_q, by: py_q, ex: qx_w, ey: qy_w};
          px_q    <= qx_w;
          py_q    <= qy_w;
          if (selx_q) begin
            xc_q <= (dx_q > 0) ? xc_q + $signed(XW'(Grain)) : xc_q - $signed(XW'(Grain));
          end else begin
            yc_q <= (dy_q > 0) ? yc_q + $signed(XW'(Grain)) : yc_q - $signed(XW'(Grain));
          end
        end
      end
      default: ;
    endcase
  end

  assign idle_o         = state_q == W_IDLE;
  assign piece_valid_o  = state_q == W_EMIT;
  assign piece_o        = piece_q;
  assign div_start_o    = div_start_q;
  assign div_dividend_o = num_q;
  assign div_divisor_o  = {den_q, 1'b0};

endmodule

// ----- hdl/car_store.sv -----
module car_store #(
  parameter int MAX_WIDTH     = 64,
  parameter int MAX_HEIGHT    = 64,
  parameter int SUBPIXEL_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]      used_w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]     used_h_i,
  input  logic                                piece_valid_i,
  output logic                                piece_ready_o,
  input  car_pkg::piece_t                     piece_i,
  input  logic                                read_start_i,
  input  logic                                out_free_i,
  output logic                                res_valid_o,
  output car_pkg::result_t                    res_o,
  output car_pkg::store_status_t              status_o
);

  localparam int Grain = 1 << SUBPIXEL_BITS;
  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int KW    = car_pkg::COORD_W;
  localparam int PCW   = KW - SUBPIXEL_BITS;
  localparam int PW    = car_pkg::POS_W;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_P0, S_P1, S_R0, S_R1} state_e;

  function automatic logic [15:0] sat16(logic signed [16:0] v);
    if (v > 17'sd32767) return 16'h7FFF;
    if (v < -17'sd32768) return 16'h8000;
    return v[15:0];
  endfunction

  state_e               state_q;
  logic [AW-1:0]        clr_q;
  logic [CW-1:0]        scan_c_q;
  logic [RW-1:0]        scan_r_q;
  logic [MAX_WIDTH-1:0] acc_vld_q;

  car_pkg::piece_t      piece_q;
  logic                 inr_q;
  logic [AW-1:0]        idx_q;
  logic signed [15:0]   wind_q;
  logic signed [32:0]   prod_q;

  logic [31:0]          cell_mem [Depth];
  logic [31:0]          cell_q;
  logic [15:0]          acc_mem [MAX_WIDTH];
  logic [15:0]          acc_q;

  logic                 cell_rd, cell_wr, acc_rd, acc_wr;
  logic [AW-1:0]        cell_ra, cell_wa;
  logic [31:0]          cell_wd;

  logic [KW-1:0]        lx, ly, dyabs;
  logic [PCW-1:0]       col_w, row_w;
  logic                 inr_w;
  logic [AW-1:0]        idx_w;
  logic signed [15:0]   wind_w;
  logic signed [16:0]   area_w;
  logic signed [32:0]   w_ext, a_ext, adj_w, edge_w;

  logic                 oob_w, wrap_w, row_last;
  logic [CW-1:0]        eff_c, nxt_c;
  logic [RW-1:0]        eff_r, nxt_r;
  logic signed [15:0]   acc_w, v16, nacc;
  logic [7:0]           pix_w;
  logic [CW+PW-1:0]     col_x;
  logic [RW+PW-1:0]     row_x;

  always_comb begin
    lx     = (piece_q.bx < piece_q.ex) ? piece_q.bx : piece_q.ex;
    ly     = (piece_q.by < piece_q.ey) ? piece_q.by : piece_q.ey;
    col_w  = lx[KW-1:SUBPIXEL_BITS];
    row_w  = ly[KW-1:SUBPIXEL_BITS];
    inr_w  = (32'(col_w) < 32'(used_w_i)) && (32'(row_w) < 32'(used_h_i));
    idx_w  = AW'(32'(row_w) * MAX_WIDTH + 32'(col_w));
    wind_w = $signed({1'b0, piece_q.bx}) - $signed({1'b0, piece_q.ex});
    dyabs  = (piece_q.by > piece_q.ey) ? piece_q.by - piece_q.ey : piece_q.ey - piece_q.by;
    area_w = $signed(17'(Grain)) - $signed({3'b000, dyabs[KW-1:1]})
           - $signed(17'(ly & KW'(Grain - 1)));
    w_ext  = {{17{wind_w[15]}}, wind_w};
    a_ext  = {{16{area_w[16]}}, area_w};
    // divide by grain, rounding toward zero
    adj_w  = prod_q + (prod_q[32] ? 33'(Grain - 1) : 33'd0);
    edge_w = adj_w >>> SUBPIXEL_BITS;

    oob_w  = (32'(scan_c_q) >= 32'(used_w_i)) || (32'(scan_r_q) >= 32'(used_h_i));
    eff_c  = oob_w ? '0 : scan_c_q;
    eff_r  = oob_w ? '0 : scan_r_q;

    acc_w  = acc_vld_q[scan_c_q] ? acc_q : 16'h0000;
    v16    = sat16({acc_w[15], acc_w} + {cell_q[15], cell_q[15:0]});
    nacc   = sat16({acc_w[15], acc_w} + {cell_q[31], cell_q[31:16]});
    pix_w  = v16[15] ? 8'h00 : ((v16 > 16'sd255) ? 8'hFF : v16[7:0]);
    row_last = 32'(scan_r_q) == 32'(used_h_i) - 32'd1;
    wrap_w = 1'b0;
    nxt_r  = scan_r_q;
    nxt_c  = '0;
    if (32'(scan_c_q) + 32'd1 >= 32'(used_w_i)) begin
      if (32'(scan_r_q) + 32'd1 >= 32'(used_h_i)) begin
        nxt_r  = '0;
        wrap_w = 1'b1;
      end else begin
        nxt_r = scan_r_q + 1'b1;
      end
    end else begin
      nxt_c = scan_c_q + 1'b1;
    end
    col_x = {{PW{1'b0}}, scan_c_q};
    row_x = {{PW{1'b0}}, scan_r_q};

    res_o.pixel_value       = pix_w;
    res_o.pixel_column      = col_x[PW-1:0];
    res_o.pixel_row         = row_x[PW-1:0];
    res_o.last_pixel        = row_last && (32'(scan_c_q) == 32'(used_w_i) - 32'd1);
    res_o.coverage_leftover = row_last && (nacc != 16'sd0);
  end

  always_comb begin
    cell_rd = 1'b0;
    cell_ra = idx_w;
    cell_wr = 1'b0;
    cell_wa = idx_q;
    cell_wd = {cell_q[31:16] + wind_q, cell_q[15:0] + edge_w[15:0]};
    acc_rd  = 1'b0;
    acc_wr  = 1'b0;
    case (state_q)
      S_CLR: begin
        cell_wr = 1'b1;
        cell_wa = clr_q;
        cell_wd = '0;
      end
      S_P0: cell_rd = inr_w;
      S_P1: cell_wr = inr_q;
      S_R0: begin
        cell_rd = out_free_i;
        cell_ra = AW'(32'(eff_r) * MAX_WIDTH + 32'(eff_c));
        acc_rd  = out_free_i;
      end
      S_R1: acc_wr = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cell_wr) cell_mem[cell_wa] <= cell_wd;
    if (cell_rd) cell_q <= cell_mem[cell_ra];
    if (acc_wr) acc_mem[scan_c_q] <= nacc;
    if (acc_rd) acc_q <= acc_mem[eff_c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      clr_q     <= '0;
      scan_c_q  <= '0;
      scan_r_q  <= '0;
      acc_vld_q <= '0;
    end else begin
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(Depth - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (piece_valid_i) state_q <= S_P0;
          else if (read_start_i) state_q <= S_R0;
        end
        S_P0: state_q <= S_P1;
        S_P1: state_q <= S_IDLE;
        S_R0: begin
          if (out_free_i) begin
            state_q  <= S_R1;
            scan_c_q <= eff_c;
            scan_r_q <= eff_r;
            if (oob_w) acc_vld_q <= '0;
          end
        end
        S_R1: begin
          state_q  <= S_IDLE;
          scan_c_q <= nxt_c;
          scan_r_q <= nxt_r;
          if (wrap_w) acc_vld_q <= '0;
          else acc_vld_q[scan_c_q] <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && piece_valid_i) piece_q <= piece_i;
    if (state_q == S_P0) begin
      inr_q  <= inr_w;
      idx_q  <= idx_w;
      wind_q <= wind_w;
      prod_q <= w_ext * a_ext;
    end
  end

  assign piece_ready_o     = state_q == S_IDLE;
  assign res_valid_o       = state_q == S_R1;
  assign status_o.idle     = state_q == S_IDLE;
  assign status_o.clearing = state_q == S_CLR;

endmodule

// ----- dv/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 20000000;
  localparam int DRAIN_CYCLES = 6000;

  class coverage_scoreboard;
    bit [31:0]                cells[4096];
    int                       col_sum[64];
    int unsigned              scan_r, scan_c;
    bit [6:0]                 width_reg, height_reg;
    car_pkg::result_t         pixel_q[$];
    int                       mismatches;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (col_sum[i]) col_sum[i] = 0;
      scan_r = 0;
      scan_c = 0;
      width_reg = car_pkg::DIM_RESET;
      height_reg = car_pkg::DIM_RESET;
      mismatches = 0;
    endfunction

    function int unsigned dim_in_use(bit [6:0] v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    function void write_reg(logic [car_pkg::CFG_IDX_W-1:0] idx,
                            logic [car_pkg::CFG_DATA_W-1:0] d);
      if (idx == car_pkg::CFG_IMAGE_WIDTH) width_reg = d;
      else if (idx == car_pkg::CFG_IMAGE_HEIGHT) height_reg = d;
    endfunction

    function int sat16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function void add_piece(longint bx, longint by, longint ex, longint ey);
      longint lx, ly, cx, cy, wind, dyabs, area, edge_t;
      bit [15:0] lo, hi;
      int idx;
      lx = bx < ex ? bx : ex;
      ly = by < ey ? by : ey;
      if (lx < 0 || ly < 0) return;
      cx = lx >> 8;
      cy = ly >> 8;
      if (cx >= dim_in_use(width_reg) || cy >= dim_in_use(height_reg)) return;
      idx = int'(cy * 64 + cx);
      wind = bx - ex;
      dyabs = by > ey ? by - ey : ey - by;
      area = 256 - dyabs / 2 - (ly & 255);
      edge_t = wind * area / 256;
      lo = cells[idx][15:0] + edge_t[15:0];
      hi = cells[idx][31:16] + wind[15:0];
      cells[idx] = {hi, lo};
    endfunction

    function longint lerp_round(longint b, longint a, longint d, longint dd);
      longint num;
      num = 2 * (b * dd + a * d) + dd;
      if (num < 0) num = 0;
      return num / (2 * dd);
    endfunction

    function void draw(longint x0, longint y0, longint x1, longint y1);
      longint dx, dy, adx, ady, xc, yc, px, py, ax, ay, qx, qy;
      bit xv, yv;
      dx = x1 - x0;
      dy = y1 - y0;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      px = x0;
      py = y0;
      if (dx == 0) return;
      xc = dx > 0 ? ((x0 + 255) >> 8) << 8 : (x0 >> 8) << 8;
      yc = dy > 0 ? ((y0 + 255) >> 8) << 8 : (y0 >> 8) << 8;
      forever begin
        ax = xc > x0 ? xc - x0 : x0 - xc;
        ay = yc > y0 ? yc - y0 : y0 - yc;
        xv = dx > 0 ? (xc < x1) : (xc > x1);
        yv = dy == 0 ? 1'b0 : (dy > 0 ? (yc < y1) : (yc > y1));
        if (!xv && !yv) break;
        if (xv && (!yv || ax * ady < ay * adx)) begin
          qx = xc;
          qy = lerp_round(y0, ax, dy, adx);
          xc += dx > 0 ? 256 : -256;
        end else begin
          qy = yc;
          qx = lerp_round(x0, ay, dx, ady);
          yc += dy > 0 ? 256 : -256;
        end
        add_piece(px, py, qx, qy);
        px = qx;
        py = qy;
      end
      add_piece(px, py, x1, y1);
    endfunction

    function void note_beat(logic kind, logic [14:0] xb, logic [14:0] yb,
                            logic [14:0] xe, logic [14:0] ye);
      int unsigned w, h;
      shortint e_term, t_term;
      int v;
      car_pkg::result_t r;
      if (kind == car_pkg::KIND_DRAW) begin
        draw(xb, yb, xe, ye);
        return;
      end
      w = dim_in_use(width_reg);
      h = dim_in_use(height_reg);
      if (scan_c >= w || scan_r >= h) begin
        scan_c = 0;
        scan_r = 0;
        foreach (col_sum[i]) col_sum[i] = 0;
      end
      e_term = cells[scan_r * 64 + scan_c][15:0];
      t_term = cells[scan_r * 64 + scan_c][31:16];
      v = sat16(col_sum[scan_c] + e_term);
      col_sum[scan_c] = sat16(col_sum[scan_c] + t_term);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      r.pixel_value = v[7:0];
      r.pixel_column = scan_c[5:0];
      r.pixel_row = scan_r[5:0];
      r.last_pixel = (scan_r == h - 1 && scan_c == w - 1);
      r.coverage_leftover = (scan_r == h - 1 && col_sum[scan_c] != 0);
      pixel_q.push_back(r);
      scan_c++;
      if (scan_c >= w) begin
        scan_c = 0;
        scan_r++;
        if (scan_r >= h) begin
          scan_r = 0;
          foreach (col_sum[i]) col_sum[i] = 0;
        end
      end
    endfunction

    function void check_pixel(car_pkg::result_t got);
      car_pkg::result_t want;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel beat %p", got);
        return;
      end
      want = pixel_q.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel mismatch: expected %p, got %p", want, got);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  car_in_if  in_if();
  car_out_if out_if();
  car_cfg_if cfg_if();
  coverage_scoreboard sb;
  int unsigned cycles;
  int unsigned burst_left;
  logic [11:0] stall_cnt;

  coverage_accumulation_rasterizer_unit i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("coverage_accumulation_rasterizer_unit regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_beat(in_if.kind, in_if.x_begin, in_if.y_begin, in_if.x_end, in_if.y_end);
    if (rst_n && cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_pixel('{out_if.pixel_value, out_if.pixel_column, out_if.pixel_row,
                       out_if.last_pixel, out_if.coverage_leftover});
  end

  // receiver stall patterns, stepping through four modes in turn
  always @(negedge clk) begin
    stall_cnt <= stall_cnt + 1'b1;
    case (stall_cnt[9:8])
      2'd0: begin
        out_if.ready <= 1'b1;
      end
      2'd1: begin
        out_if.ready <= ($urandom_range(0, 3) != 0);
      end
      2'd2: begin
        out_if.ready <= (stall_cnt[2:0] != 3'd5 && stall_cnt[2:0] != 3'd6);
      end
      default: begin
        out_if.ready <= $urandom_range(0, 1);
      end
    endcase
  end

  task automatic send_beat(logic kind, int xb, int yb, int xe, int ye);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      repeat (gap) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.x_begin <= xb[14:0];
    in_if.y_begin <= yb[14:0];
    in_if.x_end   <= xe[14:0];
    in_if.y_end   <= ye[14:0];
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
  endtask

  task automatic write_reg(logic [car_pkg::CFG_IDX_W-1:0] idx,
                           logic [car_pkg::CFG_DATA_W-1:0] d);
    @(negedge clk);
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (sb.pixel_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic int clip15(int v);
    if (v < 0) return 0;
    if (v > 32767) return 32767;
    return v;
  endfunction

  task automatic random_segment(int unsigned w, int unsigned h);
    int sx, sy, xb, yb, xe, ye;
    sx = w * 256 + 300;
    sy = h * 256 + 300;
    case ($urandom_range(0, 19))
      0: begin
        xb = $urandom_range(0, 32767);
        yb = $urandom_range(0, 32767);
        xe = $urandom_range(0, 32767);
        ye = $urandom_range(0, 32767);
      end
      1: begin
        xb = $urandom_range(0, sx);
        yb = $urandom_range(0, sy);
        xe = clip15(xb + $urandom_range(0, 1600) - 800);
        ye = yb;
      end
      2: begin
        xb = $urandom_range(0, sx);
        yb = $urandom_range(0, sy);
        xe = xb;
        ye = clip15(yb + $urandom_range(0, 1600) - 800);
      end
      3: begin
        xb = $urandom_range(0, w + 1) * 256;
        yb = $urandom_range(0, h + 1) * 256;
        xe = clip15(xb + ($urandom_range(0, 6) - 3) * 256);
        ye = clip15(yb + ($urandom_range(0, 6) - 3) * 256);
      end
      default: begin
        xb = $urandom_range(0, sx);
        yb = $urandom_range(0, sy);
        xe = clip15(xb + $urandom_range(0, 1200) - 600);
        ye = clip15(yb + $urandom_range(0, 1200) - 600);
      end
    endcase
    send_beat(car_pkg::KIND_DRAW, xb, yb, xe, ye);
  endtask

  task automatic run_phase(int wv, int hv, int n_draw, int n_read);
    int unsigned w, h;
    write_reg(car_pkg::CFG_IMAGE_WIDTH, wv[6:0]);
    write_reg(car_pkg::CFG_IMAGE_HEIGHT, hv[6:0]);
    w = sb.dim_in_use(wv[6:0]);
    h = sb.dim_in_use(hv[6:0]);
    for (int i = 0; i < n_draw + n_read; i++) begin
      if ($urandom_range(0, n_draw + n_read - 1) < n_draw && n_draw > 0) begin
        random_segment(w, h);
        n_draw--;
        i--;
        n_read++;
        n_read--;
      end else begin
        send_beat(car_pkg::KIND_READ, $urandom_range(0, 32767), $urandom_range(0, 32767),
                  $urandom_range(0, 32767), $urandom_range(0, 32767));
      end
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cycles = 0;
    burst_left = 0;
    stall_cnt = '0;
    in_if.valid = 1'b0;
    in_if.kind = car_pkg::KIND_DRAW;
    in_if.x_begin = '0;
    in_if.y_begin = '0;
    in_if.x_end = '0;
    in_if.y_end = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, on reset dimensions
    send_beat(car_pkg::KIND_DRAW, 100, 0, 100, 500);
    send_beat(car_pkg::KIND_DRAW, 10, 300, 700, 300);
    send_beat(car_pkg::KIND_DRAW, 0, 0, 512, 512);
    send_beat(car_pkg::KIND_DRAW, 768, 512, 256, 0);
    send_beat(car_pkg::KIND_DRAW, 256, 256, 600, 100);
    send_beat(car_pkg::KIND_DRAW, 900, 40, 30, 700);
    send_beat(car_pkg::KIND_DRAW, 0, 0, 16384, 16384);
    send_beat(car_pkg::KIND_DRAW, 32767, 0, 0, 32767);
    send_beat(car_pkg::KIND_DRAW, 16383, 16383, 16200, 16300);
    send_beat(car_pkg::KIND_DRAW, 0, 0, 1, 0);
    send_beat(car_pkg::KIND_DRAW, 300, 290, 299, 10);
    send_beat(car_pkg::KIND_DRAW, 5000, 50, 5600, 60);
    for (int i = 0; i < 80; i++) send_beat(car_pkg::KIND_READ, 0, 0, 0, 0);
    drain();
    write_reg(8'd2, 7'd5);
    write_reg(8'd255, 7'd127);

    run_phase(1, 64, 15, 35);
    run_phase(64, 1, 15, 35);
    run_phase(8, 4, 12, 38);
    run_phase(0, 0, 5, 3);
    run_phase(127, 127, 20, 50);
    run_phase(5, 7, 12, 38);
    run_phase(12, 10, 25, 60);
    run_phase(3, 2, 8, 12);

    if (sb.pixel_q.size() != 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("coverage_accumulation_rasterizer_unit regression: pass");
    end else begin
      $display("coverage_accumulation_rasterizer_unit regression: fail");
    end
    $finish;
  end
endmodule

// ----- coverage_accumulation_rasterizer_unit.f -----
+incdir+hdl
hdl/car_pkg.sv
hdl/car_ifs.sv
hdl/car_div.sv
hdl/car_walk.sv
hdl/car_store.sv
hdl/coverage_accumulation_rasterizer_unit.sv
dv/testbench.sv
